@@ rtl/core/dcss_pkg.sv @@
// Shared types, constants and helpers for the seven-segment scan block.
package dcss_pkg;

  localparam int unsigned NumDigits   = 4;
  localparam int unsigned DigitIdxW   = $clog2(NumDigits);
  localparam int unsigned BcdW        = 4 * NumDigits;
  localparam int unsigned DebW        = 8;
  localparam int unsigned BlinkW      = 16;
  localparam int unsigned CfgDataW    = 16;

  localparam logic [DebW-1:0]   DebounceReset = DebW'(5);
  localparam logic [BlinkW-1:0] BlinkReset    = BlinkW'(1000);

  typedef enum logic {
    CFG_DEBOUNCE_TICKS = 1'b0,
    CFG_BLINK_PERIOD   = 1'b1
  } cfg_idx_e;

  typedef logic [BcdW-1:0] bcd_t;

  typedef struct packed {
    logic toggle;
    bcd_t shown;
  } deb_status_t;

  // bit0 = a .. bit6 = g, decimal point off
  function automatic logic [7:0] seg_decode(input logic [3:0] digit);
    logic [7:0] seg;
    unique case (digit)
      4'd0:    seg = 8'h3F;
      4'd1:    seg = 8'h06;
      4'd2:    seg = 8'h5B;
      4'd3:    seg = 8'h4F;
      4'd4:    seg = 8'h66;
      4'd5:    seg = 8'h6D;
      4'd6:    seg = 8'h7D;
      4'd7:    seg = 8'h07;
      4'd8:    seg = 8'h7F;
      4'd9:    seg = 8'h6F;
      default: seg = 8'h3F;
    endcase
    return seg;
  endfunction

  // Decimal increment, wraps from all nines to zero
  function automatic bcd_t bcd_inc(input bcd_t value);
    bcd_t res;
    logic carry;
    res   = value;
    carry = 1'b1;
    for (int i = 0; i < NumDigits; i++) begin
      if (carry) begin
        if (value[4*i +: 4] >= 4'd9) begin
          res[4*i +: 4] = 4'd0;
        end else begin
          res[4*i +: 4] = value[4*i +: 4] + 4'd1;
          carry         = 1'b0;
        end
      end
    end
    return res;
  endfunction

endpackage

@@ rtl/core/dcss_debounce.sv @@
// Press debouncer with committed and shown decimal counts.
module dcss_debounce (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        step_i,
  input  logic                        level_i,
  input  logic [dcss_pkg::DebW-1:0]   limit_i,
  output dcss_pkg::deb_status_t       status_o
);
  import dcss_pkg::*;

  logic            armed_q, armed_d;
  logic [DebW-1:0] ticks_q, ticks_d;
  bcd_t            committed_q, committed_d;
  bcd_t            shown_q, shown_d;
  logic            toggle;
  logic            armed_mid;
  logic [DebW-1:0] ticks_mid;

  always_comb begin
    armed_mid   = armed_q | level_i;
    ticks_mid   = level_i ? '0 : ticks_q;
    if (armed_mid) begin
      ticks_mid = ticks_mid + DebW'(1);
    end
    toggle      = (ticks_mid >= limit_i);
    armed_d     = toggle ? 1'b0 : armed_mid;
    ticks_d     = toggle ? '0 : ticks_mid;
    shown_d     = shown_q;
    committed_d = committed_q;
    if (armed_d) begin
      shown_d = bcd_inc(committed_q);
    end else begin
      committed_d = shown_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      armed_q     <= 1'b0;
      ticks_q     <= '0;
      committed_q <= '0;
      shown_q     <= '0;
    end else if (step_i) begin
      armed_q     <= armed_d;
      ticks_q     <= ticks_d;
      committed_q <= committed_d;
      shown_q     <= shown_d;
    end
  end

  // shown is the value before this transfer's update
  assign status_o.toggle = toggle;
  assign status_o.shown  = shown_q;

endmodule

@@ rtl/core/debounced_counter_seven_segment_scan.sv @@
// Top level: four-digit multiplexed seven-segment driver with press counter and LED.
//
// One input transfer is one display tick carrying the sampled button level. Each
// tick yields exactly one result: the segment pattern and active-low enable of the
// scanned digit and the LED level after that tick's toggles. All work for a tick is
// done in the cycle it is accepted and lands in a single output register, so the
// block takes one tick per clock cycle; in_ready_o drops only while that output
// register holds a result that out_ready_i does not take. The count is kept in
// decimal digits. Write configuration only while no result is outstanding.
module debounced_counter_seven_segment_scan (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic                            button_level_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [7:0]                      segments_o,
  output logic [dcss_pkg::NumDigits-1:0]  digit_enables_o,
  output logic                            led_level_o,
  input  logic                            cfg_we_i,
  input  logic                            cfg_idx_i,
  input  logic [dcss_pkg::CfgDataW-1:0]   cfg_data_i
);
  import dcss_pkg::*;

  logic [DebW-1:0]      deb_limit_q;
  logic [BlinkW-1:0]    blink_period_q;
  logic [BlinkW-1:0]    blink_count_q, blink_count_d;
  logic [BlinkW:0]      blink_next;
  logic [DigitIdxW-1:0] scan_q;
  logic                 led_q, led_d;
  logic                 out_valid_q;
  logic [7:0]           seg_q, seg_d;
  logic [NumDigits-1:0] en_q, en_d;
  logic                 step;
  deb_status_t          deb_status;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign step       = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      deb_limit_q    <= DebounceReset;
      blink_period_q <= BlinkReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_DEBOUNCE_TICKS: deb_limit_q    <= cfg_data_i[DebW-1:0];
        CFG_BLINK_PERIOD:   blink_period_q <= cfg_data_i[BlinkW-1:0];
        default:            ;
      endcase
    end
  end

  dcss_debounce u_debounce (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .level_i  (button_level_i),
    .limit_i  (deb_limit_q),
    .status_o (deb_status)
  );

  always_comb begin
    blink_next    = {1'b0, blink_count_q} + (BlinkW+1)'(1);
    blink_count_d = (blink_next >= {1'b0, blink_period_q}) ? '0 : blink_next[BlinkW-1:0];
    seg_d         = seg_decode(deb_status.shown[4*scan_q +: 4]);
    en_d          = ~(NumDigits'(1) << scan_q);
    led_d         = led_q ^ deb_status.toggle ^ (blink_count_d == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blink_count_q <= '0;
      scan_q        <= '0;
      led_q         <= 1'b0;
    end else if (step) begin
      blink_count_q <= blink_count_d;
      scan_q        <= scan_q + DigitIdxW'(1);
      led_q         <= led_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      out_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      seg_q <= seg_d;
      en_q  <= en_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign segments_o      = seg_q;
  assign digit_enables_o = en_q;
  assign led_level_o     = led_q;

endmodule
